// ----- hdl/salc_pkg.sv -----
`timescale 1ns / 1ps

package salc_pkg;

    localparam int ADDR_BITS_DEF    = 32;
    localparam int BLOCK_BITS_DEF   = 6;
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;

    localparam int SET_BITS_W = 3;
    localparam int WAYS_W     = 4;
    localparam int CFG_DATA_W = 4;
    localparam int ACTION_W   = 2;
    localparam int EVENT_W    = 2;
    localparam int WAY_OUT_W  = 3;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RESET = 3'd6;
    localparam logic [WAYS_W-1:0]     WAYS_RESET     = 4'd8;

    typedef enum logic [0:0] {
        CFG_SET_BITS = 1'b0,
        CFG_WAYS     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        EV_HIT       = 2'd0,
        EV_WRITEBACK = 2'd1,
        EV_FILL      = 2'd2,
        EV_DONE      = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_FLUSH,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/salc_ram.sv -----
`timescale 1ns / 1ps

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/salc_front.sv -----
`timescale 1ns / 1ps

module salc_front #(
    parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF,
    parameter int QW        = ADDR_BITS + salc_pkg::ACTION_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    output logic                         ready,
    input  logic [salc_pkg::ACTION_W-1:0] action,
    input  logic [ADDR_BITS-1:0]         address,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [QW-1:0]                q_data
);

    // two-entry queue, items of no effect are dropped here
    logic [QW-1:0] buf_reg [2];
    logic [1:0]    cnt_reg;
    logic          rd_reg;
    logic          wr_reg;
    logic          push;
    logic          pop;

    assign ready   = (cnt_reg != 2'd2);
    assign push    = valid && ready && (action != salc_pkg::ACT_NONE);
    assign pop     = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= {action, address};
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
`endif

endmodule

// ----- hdl/salc_back.sv -----
`timescale 1ns / 1ps

module salc_back #(
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF,
    parameter int BLOCK_BITS   = salc_pkg::BLOCK_BITS_DEF,
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int QW           = ADDR_BITS + salc_pkg::ACTION_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [salc_pkg::SET_BITS_W-1:0]  cfg_set_bits,
    input  logic [salc_pkg::WAYS_W-1:0]      cfg_ways,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  logic [QW-1:0]                    q_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [salc_pkg::EVENT_W-1:0]     event_res,
    output logic [salc_pkg::WAY_OUT_W-1:0]   way,
    output logic [ADDR_BITS-1:0]             line_address,
    output logic [BLOCK_BITS-1:0]            block_offset,
    output logic                             last
);

    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int SETW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW    = $clog2(MAX_WAYS + 1);
    localparam int TAGW  = ADDR_BITS - BLOCK_BITS;
    localparam int ROWW  = MAX_WAYS * (TAGW + 2);
    localparam int LRUW  = MAX_WAYS * WW;

    typedef struct packed {
        logic [TAGW-1:0] tag;
        logic            valid;
        logic            dirty;
    } line_t;

    salc_pkg::state_t state_reg, state_next;

    logic [salc_pkg::ACTION_W-1:0] act_reg;
    logic [ADDR_BITS-1:0]          addr_reg;
    logic [SETW-1:0]               set_reg;
    logic [TAGW-1:0]               tag_reg;
    logic [2:0]                    sb_reg;
    logic [NW-1:0]                 n_reg;
    line_t                         row_reg [MAX_WAYS];
    logic [WW-1:0]                 ord_reg [MAX_WAYS];
    logic                          cl_busy_reg;
    logic [SETW-1:0]               cl_idx_reg;

    logic                          o_valid_reg;
    logic [salc_pkg::EVENT_W-1:0]  o_ev_reg;
    logic [WW-1:0]                 o_way_reg;
    logic [ADDR_BITS-1:0]          o_la_reg;
    logic [BLOCK_BITS-1:0]         o_off_reg;
    logic                          o_last_reg;

    logic [ROWW-1:0] row_rd, row_wd;
    logic [LRUW-1:0] lru_rd, lru_wd;
    logic            mem_we;
    logic [SETW-1:0] mem_wa;
    logic [SETW-1:0] mem_ra;

    logic            out_free;
    logic [SETW-1:0] set_in;
    logic [2:0]      sb_eff;
    logic [NW-1:0]   n_eff;

    // set and way counts clamped to their limits
    always_comb
    begin
        sb_eff = (int'(cfg_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_set_bits;
        if (cfg_ways == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(cfg_ways) > MAX_WAYS)
        begin
            n_eff = NW'(MAX_WAYS);
        end
        else
        begin
            n_eff = NW'(cfg_ways);
        end
    end

    logic [ADDR_BITS-1:0] sh_addr;
    assign sh_addr = q_data[ADDR_BITS-1:0] >> BLOCK_BITS;
    always_comb
    begin
        set_in = '0;
        for (int b = 0; b < SETW; b++)
        begin
            if (b < int'(sb_eff) && b < MAX_SET_BITS)
            begin
                set_in[b] = sh_addr[b];
            end
        end
    end

    assign out_free = !o_valid_reg || out_ready;
    assign q_ready  = (state_reg == salc_pkg::ST_IDLE) && !cl_busy_reg;

    // row memories: tags with flags, recency order
    salc_ram #(.WIDTH(ROWW), .DEPTH(NSETS)) u_rows (
        .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(row_wd),
        .raddr(mem_ra), .rdata(row_rd));
    salc_ram #(.WIDTH(LRUW), .DEPTH(NSETS)) u_lru (
        .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(lru_wd),
        .raddr(mem_ra), .rdata(lru_rd));

    assign mem_ra = set_in;

    // lookup of the loaded set
    logic            hit;
    logic [WW-1:0]   hit_w;
    logic            has_inv;
    logic [WW-1:0]   inv_w;
    logic [WW-1:0]   lru_w;
    logic [WW-1:0]   vw;
    always_comb
    begin
        hit = 1'b0;
        hit_w = '0;
        has_inv = 1'b0;
        inv_w = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < int'(n_reg))
            begin
                if (row_reg[w].valid && row_reg[w].tag == tag_reg)
                begin
                    hit = 1'b1;
                    hit_w = WW'(w);
                end
                if (!row_reg[w].valid)
                begin
                    has_inv = 1'b1;
                    inv_w = WW'(w);
                end
            end
        end
        lru_w = (int'(ord_reg[0]) >= int'(n_reg)) ? '0 : ord_reg[0];
        vw = hit ? hit_w : (has_inv ? inv_w : lru_w);
    end

    // move a way to most recently used among the active positions
    logic [WW-1:0] ord_new [MAX_WAYS];
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            ord_new[i] = ord_reg[i];
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(n_reg))
            begin
                if (ord_reg[i] == vw)
                begin
                    seen = 1'b1;
                end
                if (seen && i + 1 < int'(n_reg))
                begin
                    ord_new[i] = ord_reg[(i + 1) % MAX_WAYS];
                end
                if (i + 1 == int'(n_reg))
                begin
                    ord_new[i] = vw;
                end
            end
        end
    end

    // dirty scan for flush
    logic          fl_found;
    logic [WW-1:0] fl_w;
    always_comb
    begin
        fl_found = 1'b0;
        fl_w = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (w < int'(n_reg) && row_reg[w].valid && row_reg[w].dirty)
            begin
                fl_found = 1'b1;
                fl_w = WW'(w);
            end
        end
    end

    function automatic logic [ADDR_BITS-1:0] rebuild(input logic [TAGW-1:0] t,
                                                     input logic [SETW-1:0] s,
                                                     input logic [2:0] sb);
        logic [ADDR_BITS-1:0] a;
        a = (ADDR_BITS'(t) << (int'(sb) + BLOCK_BITS))
            | (ADDR_BITS'(s) << BLOCK_BITS);
        return a;
    endfunction

    logic victim_wb;
    assign victim_wb = !hit && !has_inv && row_reg[lru_w].valid && row_reg[lru_w].dirty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salc_pkg::ST_IDLE:
                if (q_valid && q_ready)
                begin
                    state_next = salc_pkg::ST_READ;
                end
            salc_pkg::ST_READ:
                state_next = (act_reg == salc_pkg::ACT_FLUSH) ? salc_pkg::ST_FLUSH
                                                              : salc_pkg::ST_LOOK;
            salc_pkg::ST_LOOK:
                if (out_free)
                begin
                    state_next = (hit || !victim_wb) ? salc_pkg::ST_IDLE : salc_pkg::ST_FILL;
                end
            salc_pkg::ST_FILL:
                if (out_free)
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            salc_pkg::ST_FLUSH:
                if (out_free && !fl_found)
                begin
                    state_next = salc_pkg::ST_DONE;
                end
            salc_pkg::ST_DONE:
                if (out_free)
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            default:
                state_next = salc_pkg::ST_IDLE;
        endcase
    end

    // outputs of each step
    logic                         emit;
    logic [salc_pkg::EVENT_W-1:0] e_ev;
    logic [WW-1:0]                e_way;
    logic [ADDR_BITS-1:0]         e_la;
    logic                         e_last;
    logic                         upd_row;
    logic [ADDR_BITS-1:0]         blk;
    assign blk = addr_reg & ~ADDR_BITS'((1 << BLOCK_BITS) - 1);

    always_comb
    begin
        emit = 1'b0;
        e_ev = salc_pkg::EV_HIT;
        e_way = '0;
        e_la = blk;
        e_last = 1'b1;
        upd_row = 1'b0;
        mem_we = 1'b0;
        mem_wa = set_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_wd[w*(TAGW+2) +: TAGW+2] = row_reg[w];
            lru_wd[w*WW +: WW] = ord_reg[w];
        end
        case (state_reg)
            salc_pkg::ST_LOOK:
                if (out_free)
                begin
                    emit = 1'b1;
                    if (hit)
                    begin
                        e_way = hit_w;
                        upd_row = 1'b1;
                    end
                    else if (victim_wb)
                    begin
                        e_ev = salc_pkg::EV_WRITEBACK;
                        e_way = lru_w;
                        e_la = rebuild(row_reg[lru_w].tag, set_reg, sb_reg);
                        e_last = 1'b0;
                    end
                    else
                    begin
                        e_ev = salc_pkg::EV_FILL;
                        e_way = vw;
                        upd_row = 1'b1;
                    end
                end
            salc_pkg::ST_FILL:
                if (out_free)
                begin
                    emit = 1'b1;
                    e_ev = salc_pkg::EV_FILL;
                    e_way = vw;
                    upd_row = 1'b1;
                end
            salc_pkg::ST_FLUSH:
                if (out_free && fl_found)
                begin
                    emit = 1'b1;
                    e_ev = salc_pkg::EV_WRITEBACK;
                    e_way = fl_w;
                    e_la = rebuild(row_reg[fl_w].tag, set_reg, sb_reg);
                    e_last = 1'b0;
                end
            salc_pkg::ST_DONE:
                if (out_free)
                begin
                    emit = 1'b1;
                    e_ev = salc_pkg::EV_DONE;
                    mem_we = 1'b1;
                    for (int w = 0; w < MAX_WAYS; w++)
                    begin
                        row_wd[w*(TAGW+2) +: TAGW+2] =
                            (w < int'(n_reg)) ? {row_reg[w].tag, 2'b00} : row_reg[w];
                        lru_wd[w*WW +: WW] = WW'(w);
                    end
                end
            default:
                emit = 1'b0;
        endcase
        if (upd_row)
        begin
            mem_we = 1'b1;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                lru_wd[w*WW +: WW] = ord_new[w];
                if (vw == WW'(w))
                begin
                    if (hit)
                    begin
                        row_wd[w*(TAGW+2) +: TAGW+2] = {row_reg[w].tag, 1'b1,
                            row_reg[w].dirty || act_reg == salc_pkg::ACT_WRITE};
                    end
                    else
                    begin
                        row_wd[w*(TAGW+2) +: TAGW+2] = {tag_reg, 1'b1,
                            act_reg == salc_pkg::ACT_WRITE};
                    end
                end
            end
        end
        if (cl_busy_reg)
        begin
            mem_we = 1'b1;
            mem_wa = cl_idx_reg;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                row_wd[w*(TAGW+2) +: TAGW+2] = '0;
                lru_wd[w*WW +: WW] = WW'(w);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= salc_pkg::ST_IDLE;
            o_valid_reg <= 1'b0;
            cl_busy_reg <= 1'b1;
            cl_idx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
            if (cl_busy_reg)
            begin
                cl_idx_reg <= cl_idx_reg + SETW'(1);
                if (int'(cl_idx_reg) == NSETS - 1)
                begin
                    cl_busy_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            act_reg  <= q_data[QW-1 -: salc_pkg::ACTION_W];
            addr_reg <= q_data[ADDR_BITS-1:0];
            set_reg  <= set_in;
            tag_reg  <= TAGW'(sh_addr >> sb_eff);
            sb_reg   <= sb_eff;
            n_reg    <= n_eff;
        end
        if (state_reg == salc_pkg::ST_READ)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                row_reg[w] <= row_rd[w*(TAGW+2) +: TAGW+2];
                ord_reg[w] <= lru_rd[w*WW +: WW];
            end
        end
        else if (state_reg == salc_pkg::ST_FLUSH && out_free && fl_found)
        begin
            row_reg[fl_w].dirty <= 1'b0;
        end
        if (emit)
        begin
            o_ev_reg   <= e_ev;
            o_way_reg  <= e_way;
            o_la_reg   <= e_la;
            o_off_reg  <= addr_reg[BLOCK_BITS-1:0];
            o_last_reg <= e_last;
        end
    end

    assign out_valid    = o_valid_reg;
    assign event_res    = o_ev_reg;
    assign way          = salc_pkg::WAY_OUT_W'(o_way_reg);
    assign line_address = o_la_reg;
    assign block_offset = o_off_reg;
    assign last         = o_last_reg;

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> state_reg == salc_pkg::ST_IDLE) else $error("busy take");
    a_no_clear_take: assert property (@(posedge clk) disable iff (!rst_n)
        cl_busy_reg |-> !q_ready) else $error("take during clear");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !out_ready |=> o_valid_reg && $stable(o_la_reg))
        else $error("result dropped");
`endif

endmodule

// ----- hdl/set_assoc_lru_cache_controller_top.sv -----
`timescale 1ns / 1ps
// Tag, valid, dirty and LRU control of a write-back set-associative cache.
// Input channel: valid/ready with action (read, write, flush set) and a
// byte address. Output channel: valid/ready, one word per event: hit,
// victim writeback, fill request or flush done; last marks the final word
// of an input. Configuration: wr_en, wr_index, wr_data, written only idle
// (index 0 set bits in use, index 1 ways in use); the user must keep to
// this, as the block does not enforce it. A front queue of two entries
// takes inputs while the back end works. An access passes the queue, the
// set memory read and the lookup into the output register before its
// first word; a miss with a dirty victim gives its writeback word from the
// lookup and its fill word from the fill state. A flush gives its done
// word after a writeback word for each dirty line. The back end takes a
// new input from the queue only once it is idle again after the last
// word of the previous one.
// After reset the back end clears every set, one a cycle; inputs queue
// but wait until it ends.
// A stalled receiver holds the output word and the back end waits.
module set_assoc_lru_cache_controller_top #(
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF,
    parameter int BLOCK_BITS   = salc_pkg::BLOCK_BITS_DEF,
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [salc_pkg::ACTION_W-1:0]     action,
    input  logic [ADDR_BITS-1:0]              address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [salc_pkg::EVENT_W-1:0]      event_res,
    output logic [salc_pkg::WAY_OUT_W-1:0]    way,
    output logic [ADDR_BITS-1:0]              line_address,
    output logic [BLOCK_BITS-1:0]             block_offset,
    output logic                              last
);

    localparam int QW = ADDR_BITS + salc_pkg::ACTION_W;

    logic [salc_pkg::SET_BITS_W-1:0] set_bits_reg;
    logic [salc_pkg::WAYS_W-1:0]     ways_reg;
    logic                            q_valid;
    logic                            q_ready;
    logic [QW-1:0]                   q_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= salc_pkg::SET_BITS_RESET;
            ways_reg     <= salc_pkg::WAYS_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == salc_pkg::CFG_SET_BITS)
            begin
                set_bits_reg <= wr_data[salc_pkg::SET_BITS_W-1:0];
            end
            else
            begin
                ways_reg <= wr_data;
            end
        end
    end

    salc_front #(.ADDR_BITS(ADDR_BITS), .QW(QW)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .action(action), .address(address),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

    salc_back #(.ADDR_BITS(ADDR_BITS), .BLOCK_BITS(BLOCK_BITS),
                .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .QW(QW)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_set_bits(set_bits_reg), .cfg_ways(ways_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
        .way(way), .line_address(line_address), .block_offset(block_offset),
        .last(last));

endmodule

// ----- tb/sv/set_assoc_lru_cache_checker.sv -----
`timescale 1ns / 1ps

module set_assoc_lru_cache_checker
    import salc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic                   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [ACTION_W-1:0]    action,
    input  logic [31:0]            address,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [EVENT_W-1:0]     event_res,
    input  logic [WAY_OUT_W-1:0]   way,
    input  logic [31:0]            line_address,
    input  logic [5:0]             block_offset,
    input  logic                   last,
    output int                     errors,
    output int                     pending
);

    localparam int NSETS = 64;
    localparam int NWAYS = 8;

    typedef struct {
        event_t      ev;
        logic [2:0]  way;
        logic [31:0] la;
        logic [5:0]  off;
        logic        lst;
    } cache_word_t;

    // mirror of the tag store
    logic        valid_q [NSETS][NWAYS];
    logic        dirty_q [NSETS][NWAYS];
    logic [31:0] tag_q   [NSETS][NWAYS];
    logic [2:0]  lru_q   [NSETS][NWAYS];
    logic [2:0]  sb_reg;
    logic [3:0]  ways_reg;

    cache_word_t due_words[$];

    assign pending = due_words.size();

    function automatic logic [31:0] line_of(logic [31:0] tg, int st, int sb);
        return (tg << (sb + 6)) | (32'(st) << 6);
    endfunction

    // move way w to most recently used among the first n positions
    task automatic promote(int st, int w, int n);
        int p;
        p = 0;
        while (p < n && lru_q[st][p] != 3'(w)) p++;
        for (int i = p; i + 1 < n; i++) lru_q[st][i] = lru_q[st][i + 1];
        lru_q[st][n - 1] = 3'(w);
    endtask

    task automatic push_word(event_t ev, int w, logic [31:0] la, logic [5:0] off,
                             logic lst);
        cache_word_t cw;
        cw.ev = ev;
        cw.way = 3'(w);
        cw.la = la;
        cw.off = off;
        cw.lst = lst;
        due_words.push_back(cw);
    endtask

    task automatic predict_access(action_t act, logic [31:0] addr);
        int sb, n, st, victim;
        logic [31:0] tg, blk;
        logic [5:0] off;
        sb = (sb_reg > 3'd6) ? 6 : int'(sb_reg);
        n = (ways_reg == 0) ? 1 : ((ways_reg > 4'd8) ? 8 : int'(ways_reg));
        st = int'((addr >> 6) & ((32'd1 << sb) - 1));
        tg = addr >> (6 + sb);
        off = addr[5:0];
        blk = {addr[31:6], 6'd0};
        if (act == ACT_NONE) return;
        // flush the set
        if (act == ACT_FLUSH) begin
            for (int w = 0; w < n; w++) begin
                if (valid_q[st][w] && dirty_q[st][w])
                    push_word(EV_WRITEBACK, w, line_of(tag_q[st][w], st, sb), off, 1'b0);
                valid_q[st][w] = 1'b0;
                dirty_q[st][w] = 1'b0;
            end
            for (int w = 0; w < NWAYS; w++) lru_q[st][w] = 3'(w);
            push_word(EV_DONE, 0, blk, off, 1'b1);
            return;
        end
        // lookup
        for (int w = 0; w < n; w++) begin
            if (valid_q[st][w] && tag_q[st][w] == tg) begin
                promote(st, w, n);
                if (act == ACT_WRITE) dirty_q[st][w] = 1'b1;
                push_word(EV_HIT, w, blk, off, 1'b1);
                return;
            end
        end
        // miss: lowest invalid way, else lru way
        victim = n;
        for (int w = 0; w < n; w++)
            if (!valid_q[st][w] && victim == n) victim = w;
        if (victim == n) begin
            victim = int'(lru_q[st][0]);
            if (victim >= n) victim = 0;
            if (valid_q[st][victim] && dirty_q[st][victim])
                push_word(EV_WRITEBACK, victim, line_of(tag_q[st][victim], st, sb),
                          off, 1'b0);
        end
        valid_q[st][victim] = 1'b1;
        dirty_q[st][victim] = (act == ACT_WRITE);
        tag_q[st][victim] = tg;
        promote(st, victim, n);
        push_word(EV_FILL, victim, blk, off, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_word_t cw;
        if (!rst_n)
        begin
            errors <= 0;
            sb_reg <= SET_BITS_RESET;
            ways_reg <= WAYS_RESET;
            due_words.delete();
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++)
                begin
                    valid_q[s][w] = 1'b0;
                    dirty_q[s][w] = 1'b0;
                    tag_q[s][w] = '0;
                    lru_q[s][w] = 3'(w);
                end
        end
        else
        begin
            // register writes
            if (wr_en)
            begin
                if (wr_index == CFG_SET_BITS) sb_reg <= wr_data[2:0];
                else ways_reg <= wr_data;
            end
            // accepted input word
            if (in_valid && in_ready)
                predict_access(action_t'(action), address);
            // accepted output word
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected output word: event_res %0d way %0d line_address %h",
                           event_res, way, line_address);
                    errors <= errors + 1;
                end
                else
                begin
                    cw = due_words.pop_front();
                    if (event_res != cw.ev || way != cw.way || line_address != cw.la ||
                        block_offset != cw.off || last != cw.lst)
                    begin
                        errors <= errors + 1;
                        if (event_res != cw.ev)
                            $error("event_res expected %0d actual %0d", cw.ev, event_res);
                        if (way != cw.way)
                            $error("way expected %0d actual %0d", cw.way, way);
                        if (line_address != cw.la)
                            $error("line_address expected %h actual %h", cw.la,
                                   line_address);
                        if (block_offset != cw.off)
                            $error("block_offset expected %0d actual %0d", cw.off,
                                   block_offset);
                        if (last != cw.lst)
                            $error("last expected %0d actual %0d", cw.lst, last);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_set_assoc_lru_cache_controller_top.sv -----
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_controller_top;
    import salc_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic                  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [ACTION_W-1:0]   action;
    logic [31:0]           address;
    logic                  out_valid;
    logic                  out_ready;
    logic [EVENT_W-1:0]    event_res;
    logic [WAY_OUT_W-1:0]  way;
    logic [31:0]           line_address;
    logic [5:0]            block_offset;
    logic                  last;

    int errors;
    int pending;
    int late_words;
    int words_in;
    int words_out;
    int idle_cycles;
    int stall_left;
    int cur_sb;
    int phases;
    bit long_hold_req;
    bit long_hold_done;
    bit quiet;

    set_assoc_lru_cache_controller_top uut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .action(action), .address(address),
        .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res), .way(way),
        .line_address(line_address), .block_offset(block_offset), .last(last)
    );

    set_assoc_lru_cache_checker chk (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .action(action), .address(address),
        .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res), .way(way),
        .line_address(line_address), .block_offset(block_offset), .last(last),
        .errors(errors), .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random back-pressure, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            out_ready <= 1'b0;
            stall_left <= 300;
            long_hold_done <= 1'b1;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 99) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end
        else
            out_ready <= ($urandom_range(0, 9) < 7);
    end

    // watchdog and word counts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready) words_in++;
            if (out_valid && out_ready) words_out++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] make_addr(logic [31:0] tg, int st, logic [5:0] off);
        return (tg << (6 + cur_sb)) | (32'(st) << 6) | 32'(off);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(action_t act, logic [31:0] addr);
        int gap;
        gap = pick_gap();
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        do @(posedge clk); while (!in_ready);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // settle, then write both registers
    task automatic set_config(logic [3:0] sb_val, logic [3:0] ways_val);
        drain();
        repeat (30) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= CFG_SET_BITS;
        wr_data <= sb_val;
        @(posedge clk);
        wr_index <= CFG_WAYS;
        wr_data <= ways_val;
        @(posedge clk);
        wr_en <= 1'b0;
        cur_sb = (sb_val[2:0] > 3'd6) ? 6 : int'(sb_val[2:0]);
        phases++;
    endtask

    task automatic random_phase(int count);
        int r;
        action_t act;
        logic [31:0] addr;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            act = (r < 45) ? ACT_READ : (r < 85) ? ACT_WRITE : (r < 95) ? ACT_FLUSH
                : ACT_NONE;
            if ($urandom_range(0, 9) == 0)
                addr = $urandom();
            else
                addr = make_addr($urandom_range(0, 11), $urandom_range(0, 3),
                                 6'($urandom()));
            send_word(act, addr);
        end
    endtask

    int sb_list[8]   = '{0, 7, 3, 6, 2, 6, 1, 5};
    int ways_list[8] = '{1, 0, 4, 15, 8, 8, 3, 6};

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = CFG_SET_BITS;
        wr_data = '0;
        in_valid = 1'b0;
        action = ACT_READ;
        address = '0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        long_hold_done = 1'b0;
        late_words = 0;
        words_in = 0;
        words_out = 0;
        idle_cycles = 0;
        phases = 1;
        cur_sb = 6;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill one set dirty, evict, hit, flush, extremes
        for (int w = 0; w < 8; w++)
            send_word(ACT_WRITE, make_addr(32'(w + 1), 5, 6'(w * 9)));
        send_word(ACT_READ, make_addr(32'd20, 5, 6'd63));
        send_word(ACT_READ, make_addr(32'd20, 5, 6'd0));
        send_word(ACT_WRITE, make_addr(32'd3, 5, 6'd1));
        send_word(ACT_FLUSH, make_addr(32'd0, 5, 6'd17));
        send_word(ACT_FLUSH, make_addr(32'd0, 5, 6'd2));
        send_word(ACT_NONE, 32'hFFFF_FFFF);
        send_word(ACT_READ, 32'h0000_0000);
        send_word(ACT_WRITE, 32'hFFFF_FFFF);
        send_word(ACT_READ, 32'hFFFF_FFFF);
        send_word(ACT_FLUSH, 32'hFFFF_FFFF);

        // random phases across register settings
        for (int p = 0; p < 8; p++)
        begin
            set_config(4'(sb_list[p]), 4'(ways_list[p]));
            quiet = (p == 4);
            if (p == 2) long_hold_req = 1'b1;
            random_phase(18);
            if (p == 5) drain();
            random_phase(17);
        end

        drain();
        repeat (30) @(posedge clk);
        if (pending != 0)
        begin
            $error("%0d expected words never arrived", pending);
            late_words++;
        end
        $display("covered %0d input words and %0d output words over %0d settings,",
                 words_in, words_out, phases);
        $display("including dirty evictions, set flushes and a long output hold-off");
        if (errors == 0 && late_words == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
